@@ design/tssa_pkg.sv @@
// shared types and codes for the two-stack shared-array unit
package tssa_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_DUMP = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_OVF   = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RSVD  = 2'd3
  } stat_t;

  typedef struct packed {
    op_t                      op;
    logic                     sel;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    stat_t                    status;
    logic signed [WORD_W-1:0] data;
    logic                     last;
  } res_t;

endpackage

@@ design/tssa_front.sv @@
// front end: decodes incoming requests into commands and queues them
module tssa_front import tssa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_mode,
  input  logic              in_sel,
  input  logic signed [WORD_W-1:0] in_value,
  output logic              cmd_vld,
  output cmd_t              cmd,
  input  logic              cmd_take
);

  cmd_t       q [2];
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       wp;
  logic       rp;
  logic       wr;
  logic       rd;
  cmd_t       dec;

  // classify the request
  always_comb begin
    dec.sel   = in_sel;
    dec.value = in_value;
    case (in_mode)
      OP_PUSH: dec.op = OP_PUSH;
      OP_POP:  dec.op = OP_POP;
      OP_PEEK: dec.op = OP_PEEK;
      default: dec.op = OP_DUMP;
    endcase
  end

  assign in_full  = cnt[1];
  assign cmd_vld  = (cnt != 2'd0);
  assign cmd      = q[rp];
  assign wr       = in_push && !in_full;
  assign rd       = cmd_take && cmd_vld;
  assign cnt_next = cnt + {1'b0, wr} - {1'b0, rd};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= dec;
    end
  end

endmodule

@@ design/tssa_back.sv @@
// back end: stack counters, shared word store and the result sequencer
module tssa_back import tssa_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_vld,
  input  cmd_t cmd,
  output logic cmd_take,
  input  logic res_rdy,
  output logic res_vld,
  output res_t res
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t                   state;
  state_t                   state_next;
  logic [CNT_W-1:0]         low_cnt;
  logic [CNT_W-1:0]         low_cnt_next;
  logic [CNT_W-1:0]         high_cnt;
  logic [CNT_W-1:0]         high_cnt_next;
  logic [CNT_W-1:0]         rem;
  logic [CNT_W-1:0]         rem_next;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         rd_addr_next;
  op_t                      cur_op;
  op_t                      cur_op_next;
  logic                     cur_sel;
  logic                     cur_sel_next;
  logic signed [WORD_W-1:0] mem [DEPTH];
  logic signed [WORD_W-1:0] rdata;
  logic                     we;
  logic [IDX_W-1:0]         wa;
  logic [CNT_W:0]           used;
  logic                     store_full;
  logic [CNT_W-1:0]         sel_cnt;
  logic [CNT_W-1:0]         top_idx;

  assign used       = {1'b0, low_cnt} + {1'b0, high_cnt};
  assign store_full = (used >= (CNT_W + 1)'(DEPTH));
  assign sel_cnt    = cmd.sel ? high_cnt : low_cnt;
  assign top_idx    = cmd.sel ? (CNT_W'(DEPTH) - high_cnt) : (low_cnt - CNT_W'(1));

  always_comb begin
    state_next    = state;
    low_cnt_next  = low_cnt;
    high_cnt_next = high_cnt;
    rem_next      = rem;
    rd_addr_next  = rd_addr;
    cur_op_next   = cur_op;
    cur_sel_next  = cur_sel;
    cmd_take      = 1'b0;
    res_vld       = 1'b0;
    res.status    = STAT_OK;
    res.data      = '0;
    res.last      = 1'b1;
    we            = 1'b0;
    wa            = low_cnt[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (cmd_vld && res_rdy) begin
          cmd_take = 1'b1;
          if (cmd.op == OP_PUSH) begin
            res_vld = 1'b1;
            if (store_full) begin
              res.status = STAT_OVF;
            end else begin
              we = 1'b1;
              if (cmd.sel) begin
                wa            = IDX_W'(CNT_W'(DEPTH) - high_cnt - CNT_W'(1));
                high_cnt_next = high_cnt + CNT_W'(1);
              end else begin
                low_cnt_next  = low_cnt + CNT_W'(1);
              end
            end
          end else if (sel_cnt == '0) begin
            res_vld    = 1'b1;
            res.status = STAT_EMPTY;
          end else begin
            // fetch the top word into the read register, emit it from S_EMIT
            rd_addr_next = top_idx[IDX_W-1:0];
            rem_next     = (cmd.op == OP_DUMP) ? sel_cnt : CNT_W'(1);
            cur_op_next  = cmd.op;
            cur_sel_next = cmd.sel;
            state_next   = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (res_rdy) begin
          res_vld  = 1'b1;
          res.data = rdata;
          res.last = (rem == CNT_W'(1));
          if (cur_op == OP_POP) begin
            if (cur_sel) begin
              high_cnt_next = high_cnt - CNT_W'(1);
            end else begin
              low_cnt_next  = low_cnt - CNT_W'(1);
            end
          end
          if (rem == CNT_W'(1)) begin
            state_next = S_IDLE;
          end else begin
            // dump walks from top toward the stack's own end
            rem_next     = rem - CNT_W'(1);
            rd_addr_next = cur_sel ? (rd_addr + IDX_W'(1)) : (rd_addr - IDX_W'(1));
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      low_cnt  <= '0;
      high_cnt <= '0;
    end else begin
      state    <= state_next;
      low_cnt  <= low_cnt_next;
      high_cnt <= high_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    rem     <= rem_next;
    rd_addr <= rd_addr_next;
    cur_op  <= cur_op_next;
    cur_sel <= cur_sel_next;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= cmd.value;
    end
    rdata <= mem[rd_addr_next];
  end

endmodule

@@ design/tssa_res_q.sv @@
// two-entry result queue in front of the result ports
module tssa_res_q import tssa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic res_vld,
  input  res_t res,
  output logic res_rdy,
  output logic out_empty,
  input  logic out_pop,
  output res_t out_res
);

  res_t       q [2];
  logic [1:0] cnt;
  logic [1:0] cnt_next;
  logic       wp;
  logic       rp;
  logic       wr;
  logic       rd;

  assign res_rdy   = !cnt[1];
  assign out_empty = (cnt == 2'd0);
  assign out_res   = q[rp];
  assign wr        = res_vld && res_rdy;
  assign rd        = out_pop && !out_empty;
  assign cnt_next  = cnt + {1'b0, wr} - {1'b0, rd};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (wr) begin
        wp <= ~wp;
      end
      if (rd) begin
        rp <= ~rp;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      q[wp] <= res;
    end
  end

endmodule

@@ design/two_stacks_shared_array_unit.sv @@
// top level: two stacks sharing one word store, queue-style ports
// path: pushes and empty reports pass through the front queue and the result queue;
//   pop, peek and dumped words also pass through the registered read of the store
// throughput: one push per cycle while the result queue has room; a pop, peek or dump
//   holds off the next request until its last word is out, set by the single read port behind a registered read
// reset: synchronous, clears both stack counts and all queues; the store is not cleared
module two_stacks_shared_array_unit import tssa_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  // request side
  input  logic              push,
  output logic              full,
  input  logic [1:0]        mode,
  input  logic              stack_sel,
  input  logic signed [31:0] push_value,
  // result side
  output logic              empty,
  input  logic              pop,
  output logic [1:0]        status,
  output logic signed [31:0] data_word,
  output logic              last
);

  // decoded commands between front and back
  logic cmd_vld;
  cmd_t cmd;
  logic cmd_take;

  // results from the back end into the output queue
  logic res_vld;
  logic res_rdy;
  res_t res;
  res_t out_res;

  // front: decode and buffer requests so the back can stall on its own
  tssa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_push  (push),
    .in_full  (full),
    .in_mode  (mode),
    .in_sel   (stack_sel),
    .in_value (push_value),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd),
    .cmd_take (cmd_take)
  );

  // back: counters, store, and the dump walker
  tssa_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_vld  (cmd_vld),
    .cmd      (cmd),
    .cmd_take (cmd_take),
    .res_rdy  (res_rdy),
    .res_vld  (res_vld),
    .res      (res)
  );

  // output queue decouples the back end from the consumer
  tssa_res_q u_res_q (
    .clk       (clk),
    .rst       (rst),
    .res_vld   (res_vld),
    .res       (res),
    .res_rdy   (res_rdy),
    .out_empty (empty),
    .out_pop   (pop),
    .out_res   (out_res)
  );

  assign status    = out_res.status;
  assign data_word = out_res.data;
  assign last      = out_res.last;

endmodule

@@ verif/tb_top.sv @@
// testbench for the two-stack shared-array unit: directed and random requests, self-checking
`timescale 1ns / 100ps

module tb_top;
  import tssa_pkg::*;

  localparam int DEPTH       = 32;
  localparam int STALL_LIMIT = 3000;  // cycles without any handshake before giving up
  localparam int SHOW_MAX    = 10;    // mismatches printed in full

  // clock and reset
  logic clk = 1'b0;
  logic rst;
  always #6 clk = ~clk;

  // request side
  logic               push;
  logic               full;
  logic [1:0]         mode;
  logic               stack_sel;
  logic signed [31:0] push_value;

  // result side
  logic               empty;
  logic               pop;
  logic [1:0]         status;
  logic signed [31:0] data_word;
  logic               last;

  two_stacks_shared_array_unit #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .mode      (mode),
    .stack_sel (stack_sel),
    .push_value(push_value),
    .empty     (empty),
    .pop       (pop),
    .status    (status),
    .data_word (data_word),
    .last      (last)
  );

  // idle percentages for the two sides, changed between phases
  int send_idle_pct;
  int recv_idle_pct;

  // shadow copy of the block state
  logic [31:0] word_store [DEPTH];
  int          low_count;
  int          high_count;

  // replies the block owes us, oldest first
  res_t stack_replies [$];

  // bookkeeping
  int mismatches;
  int requests_sent;
  int replies_seen;
  int overflow_reports;
  int empty_reports;
  int longest_dump;
  int stall_cycles;
  logic took_any;

  task automatic add_reply(stat_t st, logic [31:0] word, logic fin);
    res_t r;
    r.status = st;
    r.data   = word;
    r.last   = fin;
    stack_replies.push_back(r);
  endtask

  // advance the shadow state by one request and queue the replies it causes
  task automatic apply_stack_op(op_t op, logic sel, logic [31:0] val);
    int depth_now;
    int top;
    depth_now = sel ? high_count : low_count;
    if (op == OP_PUSH) begin
      if (low_count + high_count >= DEPTH) begin
        // both stacks together fill the store, push refused either way
        add_reply(STAT_OVF, 32'd0, 1'b1);
        overflow_reports++;
      end else begin
        if (!sel) begin
          word_store[low_count] = val;
          low_count++;
        end else begin
          high_count++;
          word_store[DEPTH - high_count] = val;
        end
        add_reply(STAT_OK, 32'd0, 1'b1);
      end
    end else if (depth_now == 0) begin
      // pop, peek or dump of an empty stack gives one empty report
      add_reply(STAT_EMPTY, 32'd0, 1'b1);
      empty_reports++;
    end else begin
      top = sel ? DEPTH - high_count : low_count - 1;
      if (op == OP_DUMP) begin
        // top to bottom: the low stack walks down, the high stack walks up
        for (int n = 0; n < depth_now; n++)
          add_reply(STAT_OK, word_store[sel ? top + n : top - n], n + 1 == depth_now);
        if (depth_now > longest_dump) longest_dump = depth_now;
      end else begin
        add_reply(STAT_OK, word_store[top], 1'b1);
        if (op == OP_POP) begin
          if (!sel) low_count--;
          else high_count--;
        end
      end
    end
  endtask

  // drive one request at the falling edge and hold it until the block takes it;
  // push stays high after acceptance so back-to-back requests need no reassignment
  task automatic send_request(op_t op, logic sel, logic [31:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push       <= 1'b1;
    mode       <= op;
    stack_sel  <= sel;
    push_value <= val;
    @(posedge clk);
    while (full) @(posedge clk);
    apply_stack_op(op, sel, val);
    requests_sent++;
  endtask

  // receiver: random stalls on pop, changed at the falling edge
  always @(negedge clk) begin
    pop <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // result checker and handshake activity counter, sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      stall_cycles = 0;
    end else begin
      took_any = push && !full;
      if (pop && !empty) begin
        took_any = 1'b1;
        replies_seen++;
        if (stack_replies.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_MAX)
            $display("unexpected result: status %0d word %h last %b",
                     status, data_word, last);
        end else begin
          res_t want;
          want = stack_replies.pop_front();
          if (status !== want.status || data_word !== want.data || last !== want.last) begin
            mismatches++;
            if (mismatches <= SHOW_MAX)
              $display("res %0d: status exp %0d got %0d, word exp %h got %h, last exp %b got %b",
                       replies_seen, want.status, status, want.data, data_word,
                       want.last, last);
          end
        end
      end
      stall_cycles = took_any ? 0 : stall_cycles + 1;
    end
  end

  // watchdog: a long stretch with no handshake at all means the block hung
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("watchdog: no handshake for %0d cycles, %0d results still owed",
             STALL_LIMIT, stack_replies.size());
    $display("FAILED: results differ");
    $finish;
  end

  // word with a bias toward the extremes of the signed range
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 11))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // pop, peek and dump with nothing stored, on both stacks
  task automatic test_empty_reports();
    send_request(OP_POP,  1'b0, 32'h1234_5678);
    send_request(OP_POP,  1'b1, 32'hffff_ffff);
    send_request(OP_PEEK, 1'b0, 32'h0000_0000);
    send_request(OP_PEEK, 1'b1, 32'h8000_0000);
    send_request(OP_DUMP, 1'b0, 32'h7fff_ffff);
    send_request(OP_DUMP, 1'b1, 32'h5a5a_5a5a);
  endtask

  // extreme words through both stacks, peek before pop
  task automatic test_push_pop_extremes();
    send_request(OP_PUSH, 1'b0, 32'h7fff_ffff);
    send_request(OP_PUSH, 1'b0, 32'h8000_0000);
    send_request(OP_PUSH, 1'b1, 32'hffff_ffff);
    send_request(OP_PUSH, 1'b1, 32'h0000_0000);
    send_request(OP_PEEK, 1'b0, 32'h0);
    send_request(OP_PEEK, 1'b1, 32'h0);
    send_request(OP_POP,  1'b0, 32'h0);
    send_request(OP_POP,  1'b1, 32'h0);
  endtask

  // dump order and last flag on short stacks, then drain both
  task automatic test_dump_order();
    send_request(OP_PUSH, 1'b0, 32'h5555_5555);
    send_request(OP_PUSH, 1'b1, 32'haaaa_aaaa);
    send_request(OP_DUMP, 1'b0, 32'h0);
    send_request(OP_DUMP, 1'b1, 32'h0);
    send_request(OP_POP,  1'b0, 32'h0);
    send_request(OP_POP,  1'b0, 32'h0);
    send_request(OP_POP,  1'b1, 32'h0);
    send_request(OP_POP,  1'b1, 32'h0);
  endtask

  // store full from one stack alone, then a split between both, with refused pushes
  task automatic test_full_store();
    while (low_count + high_count < DEPTH)
      send_request(OP_PUSH, 1'b0, pick_word());
    send_request(OP_PUSH, 1'b1, pick_word());
    send_request(OP_PUSH, 1'b0, pick_word());
    send_request(OP_DUMP, 1'b0, 32'h0);           // longest possible dump
    send_request(OP_DUMP, 1'b1, 32'h0);
    repeat (DEPTH / 2) send_request(OP_POP, 1'b0, 32'h0);
    while (low_count + high_count < DEPTH)
      send_request(OP_PUSH, 1'b1, pick_word());
    send_request(OP_PUSH, 1'b1, pick_word());
    send_request(OP_PUSH, 1'b0, pick_word());
    send_request(OP_DUMP, 1'b1, 32'h0);
    send_request(OP_DUMP, 1'b0, 32'h0);
  endtask

  // random traffic in runs of 20 with a push-heavy, balanced or pop-heavy mix,
  // so the stacks swing between full and empty
  task automatic test_random_traffic(int n_items);
    int push_pct;
    int pick;
    op_t op;
    push_pct = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % 20 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
      end
      if ($urandom_range(0, 99) < push_pct) begin
        op = OP_PUSH;
      end else begin
        pick = $urandom_range(0, 9);
        op = (pick < 4) ? OP_POP : (pick < 7) ? OP_PEEK : OP_DUMP;
      end
      send_request(op, 1'($urandom_range(0, 1)), pick_word());
    end
  endtask

  initial begin
    rst           = 1'b1;
    push          = 1'b0;
    mode          = OP_PUSH;
    stack_sel     = 1'b0;
    push_value    = '0;
    send_idle_pct = 21;
    recv_idle_pct = 77;
    low_count     = 0;
    high_count    = 0;
    mismatches    = 0;
    requests_sent = 0;
    replies_seen  = 0;
    overflow_reports = 0;
    empty_reports = 0;
    longest_dump  = 0;
    for (int i = 0; i < DEPTH; i++) word_store[i] = '0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // phase one: slow receiver
    test_empty_reports();
    test_push_pop_extremes();
    test_dump_order();
    test_full_store();
    test_random_traffic(125);

    // phase two: slow sender
    send_idle_pct = 77;
    recv_idle_pct = 21;
    test_random_traffic(125);

    // phase three: both sides at full rate
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(126);

    @(negedge clk);
    push <= 1'b0;
    recv_idle_pct = 0;

    // drain what is owed, then leave room for any stray result
    while (stack_replies.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("run covered %0d requests and %0d results over three idle mixes",
             requests_sent, replies_seen);
    $display("refused pushes %0d, empty reports %0d, longest dump %0d words",
             overflow_reports, empty_reports, longest_dump);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatching results", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
